>>> design/lkbc_pkg.sv
// Shared constants, status codes and cell control type for the keyed block cache.
package lkbc_pkg;

  localparam int LKBC_STORE_DEPTH = 16;
  localparam int LKBC_KEY_BITS    = 64;
  localparam int LKBC_DATA_BITS   = 64;

  localparam int MODE_W   = 1;
  localparam int KEY_W    = 64;
  localparam int DATA_W   = 64;
  localparam int STATUS_W = 3;
  localparam int LIMIT_W  = 5;

  localparam logic [MODE_W-1:0] MODE_READ  = 1'b0;
  localparam logic [MODE_W-1:0] MODE_WRITE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_READ_MISS = 3'd0;
  localparam logic [STATUS_W-1:0] ST_READ_HIT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_WRITE_DUP = 3'd2;
  localparam logic [STATUS_W-1:0] ST_STORED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EVICTED   = 3'd4;

  // Per-cell control: capture the compare, apply the shift, drop the entry.
  typedef struct packed {
    logic look;
    logic update;
    logic kill;
  } lkbc_cell_ctrl_t;

endpackage

>>> design/lkbc_if.sv
// Request and response channel interfaces of the keyed block cache.
interface lkbc_req_if;
  logic                      valid;
  logic                      ready;
  logic [lkbc_pkg::MODE_W-1:0] mode;
  logic [lkbc_pkg::KEY_W-1:0]  key;
  logic [lkbc_pkg::DATA_W-1:0] write_data;

  modport source (output valid, output mode, output key, output write_data, input ready);
  modport sink   (input valid, input mode, input key, input write_data, output ready);
endinterface

interface lkbc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lkbc_pkg::STATUS_W-1:0] status;
  logic [lkbc_pkg::DATA_W-1:0]   read_data;

  modport source (output valid, output status, output read_data, input ready);
  modport sink   (input valid, input status, input read_data, output ready);
endinterface

>>> design/lru_keyed_block_cache_core.sv
// Top level of the fully associative LRU cache keyed by content digest.
// Usage:
//   req channel: mode (0 read, 1 write), key, write_data. A word is taken
//   when valid and ready are both high. Only the low KEY_BITS of key and the
//   low DATA_BITS of write_data are used.
//   rsp channel: status and read_data, one word per request word, in order.
//   cfg_write_en / cfg_write_data set entry_limit (0 or above STORE_DEPTH
//   means the whole store); write it only while the cache is idle.
// Sequence:
//   The response is registered after the request is taken: the look state
//   compares the key against every cell, then the update state shifts the
//   cell chain to put the touched entry at the head. A new request is taken
//   in the update state, so a word can be accepted before the last one is
//   through the compare-then-shift sequence on the cell chain.
// Reset (rst, synchronous): all entries invalid, count and limit zero.
// Stall: a held response keeps the next request in its update cycle and
//   ready low until the response word leaves.
// Cells are kept in recency order: cell 0 is the most recent entry and the
//   valid cells always form a prefix of the chain.
module lru_keyed_block_cache_core #(
  parameter int STORE_DEPTH = lkbc_pkg::LKBC_STORE_DEPTH,
  parameter int KEY_BITS    = lkbc_pkg::LKBC_KEY_BITS,
  parameter int DATA_BITS   = lkbc_pkg::LKBC_DATA_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_en,
  input  logic [lkbc_pkg::LIMIT_W-1:0] cfg_write_data,
  lkbc_req_if.sink                     req,
  lkbc_rsp_if.source                   rsp
);
  import lkbc_pkg::*;

  localparam int CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int CMP_W = ((CNT_W > LIMIT_W) ? CNT_W : LIMIT_W) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_UPDATE
  } state_t;

  state_t                 state;
  logic [LIMIT_W-1:0]     entry_limit;
  logic [CNT_W-1:0]       entry_count;
  logic [MODE_W-1:0]      mode_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [DATA_BITS-1:0]   wdata_q;
  logic                   any_hit;
  logic [DATA_BITS-1:0]   hit_data;

  logic                   rsp_free;
  logic                   take;
  logic                   do_update;
  logic                   new_key;
  logic                   evict;
  logic [CMP_W-1:0]       limit_eff;
  logic [CMP_W-1:0]       count_plus;
  logic [CNT_W-1:0]       entry_count_next;
  logic                   any_hit_next;
  logic [DATA_BITS-1:0]   hit_data_next;
  logic [STATUS_W-1:0]    status_next;

  logic [DATA_BITS-1:0]   head_data;
  lkbc_cell_ctrl_t        cell_ctrl [STORE_DEPTH];
  logic                   cell_hit  [STORE_DEPTH];
  logic                   cell_held [STORE_DEPTH];
  logic                   cell_valid [STORE_DEPTH];
  logic [KEY_BITS-1:0]    cell_key  [STORE_DEPTH];
  logic [DATA_BITS-1:0]   cell_data [STORE_DEPTH];
  logic                   shift_chain [STORE_DEPTH+1];

  // Handshake: take a word when idle, or in the update cycle when the
  // response slot will be free.
  assign rsp_free  = !rsp.valid || rsp.ready;
  assign do_update = (state == S_UPDATE) && rsp_free;
  assign req.ready = (state == S_IDLE) || do_update;
  assign take      = req.valid && req.ready;

  // Eviction decision: compare the grown count against the effective limit.
  assign new_key    = (mode_q == MODE_WRITE) && !any_hit;
  assign count_plus = CMP_W'(entry_count) + CMP_W'(1);
  always_comb begin
    if (entry_limit == '0 || CMP_W'(entry_limit) > CMP_W'(STORE_DEPTH)) begin
      limit_eff = CMP_W'(STORE_DEPTH);
    end else begin
      limit_eff = CMP_W'(entry_limit);
    end
  end
  assign evict = new_key && (count_plus > limit_eff);
  assign entry_count_next = entry_count + CNT_W'(1) - CNT_W'(evict);

  always_comb begin
    if (mode_q == MODE_READ) begin
      status_next = any_hit ? ST_READ_HIT : ST_READ_MISS;
    end else if (any_hit) begin
      status_next = ST_WRITE_DUP;
    end else begin
      status_next = evict ? ST_EVICTED : ST_STORED;
    end
  end

  // Gather the hit entry's payload: at most one cell matches.
  always_comb begin
    any_hit_next  = 1'b0;
    hit_data_next = '0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      any_hit_next  = any_hit_next | cell_hit[i];
      hit_data_next = hit_data_next | (cell_hit[i] ? cell_data[i] : '0);
    end
  end

  // Head of the chain: the new key on insert, the hit entry on a read hit.
  assign head_data = (mode_q == MODE_WRITE) ? wdata_q : hit_data;

  // Only a new key shifts the whole chain; a read hit shifts from its cell.
  assign shift_chain[STORE_DEPTH] = new_key;

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    always_comb begin
      cell_ctrl[i].look   = (state == S_LOOK);
      cell_ctrl[i].update = do_update && (new_key || (mode_q == MODE_READ && any_hit));
      // Drop the entry that falls past the old count when evicting.
      cell_ctrl[i].kill   = evict && (entry_count == CNT_W'(i));
    end

    if (i == 0) begin : g_head
      lkbc_cell #(
        .KEY_BITS  (KEY_BITS),
        .DATA_BITS (DATA_BITS)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (cell_ctrl[i]),
        .lookup_key (key_q),
        .prev_valid (1'b1),
        .prev_key   (key_q),
        .prev_data  (head_data),
        .shift_in   (shift_chain[i+1]),
        .shift_out  (shift_chain[i]),
        .hit        (cell_hit[i]),
        .hit_held   (cell_held[i]),
        .valid      (cell_valid[i]),
        .key        (cell_key[i]),
        .data       (cell_data[i])
      );
    end else begin : g_body
      lkbc_cell #(
        .KEY_BITS  (KEY_BITS),
        .DATA_BITS (DATA_BITS)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (cell_ctrl[i]),
        .lookup_key (key_q),
        .prev_valid (cell_valid[i-1]),
        .prev_key   (cell_key[i-1]),
        .prev_data  (cell_data[i-1]),
        .shift_in   (shift_chain[i+1]),
        .shift_out  (shift_chain[i]),
        .hit        (cell_hit[i]),
        .hit_held   (cell_held[i]),
        .valid      (cell_valid[i]),
        .key        (cell_key[i]),
        .data       (cell_data[i])
      );
    end
  end

  // Sequencer, count, limit and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_limit <= '0;
      entry_count <= '0;
      any_hit     <= 1'b0;
      rsp.valid   <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        entry_limit <= cfg_write_data;
      end
      // Drop valid once the word leaves, unless a new word replaces it.
      if (rsp.valid && rsp.ready && !do_update) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          any_hit <= any_hit_next;
          state   <= S_UPDATE;
        end
        S_UPDATE: begin
          if (do_update) begin
            rsp.valid <= 1'b1;
            if (new_key) begin
              entry_count <= entry_count_next;
            end
            state <= take ? S_LOOK : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers: request capture, hit payload and response word.
  always_ff @(posedge clk) begin
    if (take) begin
      mode_q  <= req.mode;
      key_q   <= req.key[KEY_BITS-1:0];
      wdata_q <= req.write_data[DATA_BITS-1:0];
    end
    if (state == S_LOOK) begin
      hit_data <= hit_data_next;
    end
    if (do_update) begin
      rsp.status    <= status_next;
      rsp.read_data <= (mode_q == MODE_READ && any_hit) ? DATA_W'(hit_data) : '0;
    end
  end

endmodule

>>> design/lkbc_cell.sv
// One recency-ordered cache cell: holds an entry and takes its neighbor's on a shift.
module lkbc_cell #(
  parameter int KEY_BITS  = lkbc_pkg::LKBC_KEY_BITS,
  parameter int DATA_BITS = lkbc_pkg::LKBC_DATA_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  lkbc_pkg::lkbc_cell_ctrl_t ctrl,
  input  logic [KEY_BITS-1:0]       lookup_key,
  input  logic                      prev_valid,
  input  logic [KEY_BITS-1:0]       prev_key,
  input  logic [DATA_BITS-1:0]      prev_data,
  input  logic                      shift_in,
  output logic                      shift_out,
  output logic                      hit,
  output logic                      hit_held,
  output logic                      valid,
  output logic [KEY_BITS-1:0]       key,
  output logic [DATA_BITS-1:0]      data
);
  import lkbc_pkg::*;

  assign hit       = valid && (key == lookup_key);
  // Cells at or above the hit (or all cells on a new key) move down one place.
  assign shift_out = hit_held | shift_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      hit_held <= 1'b0;
    end else begin
      if (ctrl.look) begin
        hit_held <= hit;
      end
      if (ctrl.update && shift_out) begin
        valid <= prev_valid && !ctrl.kill;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.update && shift_out) begin
      key  <= prev_key;
      data <= prev_data;
    end
  end

endmodule

>>> sim/tb_lru_keyed_block_cache_core.sv
// Self-checking testbench for the digest-keyed LRU block cache core.
module tb_lru_keyed_block_cache_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lkbc_pkg::*;

  localparam int DEPTH       = LKBC_STORE_DEPTH;
  localparam int POOL_SIZE   = DEPTH + 8;
  localparam int PHASE_WORDS = 100;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 20;

  // Only the low KEY_BITS / DATA_BITS take part in lookup and storage.
  localparam logic [KEY_W-1:0]  KEY_MASK  = {KEY_W{1'b1}} >> (KEY_W - LKBC_KEY_BITS);
  localparam logic [DATA_W-1:0] DATA_MASK = {DATA_W{1'b1}} >> (DATA_W - LKBC_DATA_BITS);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   read_data;
  } cache_reply_t;

  // Mirror of the cache: slots with keys, payloads, live flags and ages
  // (age 0 is the most recent), plus the queue of replies still owed.
  class lkbc_scoreboard;
    logic [KEY_W-1:0]  slot_key  [DEPTH];
    logic [DATA_W-1:0] slot_data [DEPTH];
    bit                slot_live [DEPTH];
    int unsigned       slot_age  [DEPTH];
    int unsigned       live_count;
    logic [LIMIT_W-1:0] limit_reg;
    cache_reply_t      replies_due[$];
    int                errors;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        slot_key[i]  = '0;
        slot_data[i] = '0;
        slot_live[i] = 1'b0;
        slot_age[i]  = 0;
      end
      live_count = 0;
      limit_reg  = '0;
      errors     = 0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] v);
      limit_reg = v;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    function void report_mismatch(string what);
      errors++;
      $display("ERROR @%0t: %s", $realtime, what);
    endfunction

    // Predict the reply to one accepted request word and update the mirror.
    function void note_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                               logic [DATA_W-1:0] wdata);
      cache_reply_t r;
      logic [KEY_W-1:0]  k;
      logic [DATA_W-1:0] d;
      int          hit;
      int          slot;
      int unsigned age;
      int unsigned cap;
      bit          evict;
      k = key & KEY_MASK;
      d = wdata & DATA_MASK;
      r.status    = ST_READ_MISS;
      r.read_data = '0;
      hit = -1;
      for (int i = 0; i < DEPTH; i++)
        if (hit < 0 && slot_live[i] && slot_key[i] == k) hit = i;

      if (mode == MODE_READ) begin
        if (hit >= 0) begin
          // Promote: everything younger than the hit ages by one.
          age = slot_age[hit];
          for (int i = 0; i < DEPTH; i++)
            if (slot_live[i] && slot_age[i] < age) slot_age[i]++;
          slot_age[hit] = 0;
          r.status    = ST_READ_HIT;
          r.read_data = slot_data[hit] & DATA_MASK;
        end
      end else if (hit >= 0) begin
        // Duplicate write: no payload update, no reorder.
        r.status = ST_WRITE_DUP;
      end else begin
        cap = (limit_reg == 0 || limit_reg > DEPTH) ? DEPTH : limit_reg;
        evict = (live_count + 1) > cap;
        slot = -1;
        if (evict && live_count > 0) begin
          // Drop only the single oldest entry, even if the limit was lowered.
          for (int i = 0; i < DEPTH; i++)
            if (slot_live[i] && slot_age[i] == live_count - 1) slot = i;
          if (slot >= 0) begin
            slot_live[slot] = 1'b0;
            live_count--;
          end
        end else begin
          evict = 1'b0;
        end
        for (int i = 0; i < DEPTH && slot < 0; i++)
          if (!slot_live[i]) slot = i;
        if (slot < 0) begin
          r.status = ST_WRITE_DUP;
        end else begin
          for (int i = 0; i < DEPTH; i++)
            if (slot_live[i]) slot_age[i]++;
          slot_key[slot]  = k;
          slot_data[slot] = d;
          slot_live[slot] = 1'b1;
          slot_age[slot]  = 0;
          live_count++;
          r.status = evict ? ST_EVICTED : ST_STORED;
        end
      end
      replies_due.push_back(r);
    endfunction

    // Compare one accepted response word with the oldest owed reply.
    function void check_reply(logic [STATUS_W-1:0] status, logic [DATA_W-1:0] rdata);
      cache_reply_t want;
      if (replies_due.size() == 0) begin
        report_mismatch($sformatf("unexpected response status=%0d data=%h", status, rdata));
        return;
      end
      want = replies_due.pop_front();
      if (status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
      if (rdata !== want.read_data)
        report_mismatch($sformatf("read_data %h, expected %h", rdata, want.read_data));
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic [LIMIT_W-1:0] cfg_write_data;

  lkbc_req_if req_ch();
  lkbc_rsp_if rsp_ch();

  lru_keyed_block_cache_core uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .req            (req_ch),
    .rsp            (rsp_ch)
  );

  lkbc_scoreboard sb = new();

  // Idle odds in percent for each side; the main sequence retunes them.
  int send_gap_pct = 29;
  int recv_gap_pct = 50;
  int pool_span    = POOL_SIZE;
  int unsigned cycle_count = 0;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if the traffic never drains.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: toggle ready at the falling edge so it is stable at the rising edge.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Monitor: every word taken off the response channel is checked.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_reply(rsp_ch.status, rsp_ch.read_data);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Present one request word from a falling edge and hold it until taken.
  // Return at the falling edge after acceptance with valid still high.
  task automatic send_word(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                           logic [DATA_W-1:0] wdata);
    while ($urandom_range(99) < send_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.mode       <= mode;
    req_ch.key        <= key;
    req_ch.write_data <= wdata;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(mode, key, wdata);
    @(negedge clk);
  endtask

  // Drain the cache, then write the limit register while it is idle.
  task automatic set_limit(logic [LIMIT_W-1:0] v);
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    sb.set_limit(v);
    // Keep the key pool near the effective limit so hits and evictions mix.
    pool_span = ((v == 0 || v > DEPTH) ? DEPTH : v) + 4;
    if (pool_span > POOL_SIZE) pool_span = POOL_SIZE;
  endtask

  // Mostly pool keys so that lookups hit; some fresh digests for misses.
  task automatic random_word();
    logic [MODE_W-1:0] m;
    logic [KEY_W-1:0]  k;
    m = $urandom_range(1) ? MODE_WRITE : MODE_READ;
    if ($urandom_range(99) < 12) k = rand64();
    else k = key_pool[$urandom_range(pool_span - 1)];
    send_word(m, k, rand64());
  endtask

  localparam logic [KEY_W-1:0] KEY_ZERO = '0;
  localparam logic [KEY_W-1:0] KEY_ONES = '1;
  localparam logic [LIMIT_W-1:0] PHASE_LIMITS [8] = '{5'd16, 5'd3, 5'd1, 5'd31,
                                                    5'd17, 5'd8, 5'd2, 5'd0};

  initial begin
    rst               = 1'b1;
    cfg_write_en      = 1'b0;
    cfg_write_data    = '0;
    req_ch.valid      = 1'b0;
    req_ch.mode       = MODE_READ;
    req_ch.key        = '0;
    req_ch.write_data = '0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = rand64();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty-store miss, extreme keys and payloads, duplicate write
    // keeps the old payload, then eviction at small limits.
    send_word(MODE_READ,  KEY_ZERO, '1);
    send_word(MODE_WRITE, KEY_ZERO, '1);
    send_word(MODE_WRITE, KEY_ONES, '0);
    send_word(MODE_WRITE, KEY_ZERO, 64'h5555_5555_5555_5555);
    send_word(MODE_READ,  KEY_ZERO, '0);
    send_word(MODE_READ,  KEY_ONES, '1);
    send_word(MODE_READ,  64'h1234, '0);
    set_limit(5'd2);
    send_word(MODE_WRITE, 64'hA5A5_A5A5_A5A5_A5A5, 64'h3C3C_3C3C_3C3C_3C3C);
    send_word(MODE_READ,  KEY_ONES, '0);
    send_word(MODE_READ,  KEY_ZERO, '0);
    // Limit lowered below the count: reads and duplicates evict nothing,
    // each new key drops just the oldest entry.
    set_limit(5'd1);
    send_word(MODE_READ,  64'hA5A5_A5A5_A5A5_A5A5, '0);
    send_word(MODE_WRITE, KEY_ONES, 64'hFFFF_0000_FFFF_0000);
    send_word(MODE_WRITE, 64'h8000_0000_0000_0001, 64'h0123_4567_89AB_CDEF);
    send_word(MODE_WRITE, 64'h1, 64'hFEDC_BA98_7654_3210);
    send_word(MODE_READ,  64'h8000_0000_0000_0001, '0);
    send_word(MODE_READ,  64'h1, '0);
    send_word(MODE_READ,  KEY_ONES, '0);

    // Random phases: sender-light idling, then receiver-light, then none.
    for (int p = 0; p < 8; p++) begin
      set_limit(PHASE_LIMITS[p]);
      if (p < 3) begin
        send_gap_pct = 29;
        recv_gap_pct = 50;
      end else if (p < 6) begin
        send_gap_pct = 50;
        recv_gap_pct = 29;
      end else begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      // Fill the store first in the full-size phase so the full case is hit.
      if (PHASE_LIMITS[p] == 5'd16)
        for (int i = 0; i < DEPTH + 2; i++) send_word(MODE_WRITE, key_pool[i], rand64());
      for (int n = 0; n < PHASE_WORDS; n++) random_word();
    end

    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d responses never arrived", sb.pending()));

    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
design/lkbc_pkg.sv
design/lkbc_if.sv
design/lkbc_cell.sv
design/lru_keyed_block_cache_core.sv
sim/tb_lru_keyed_block_cache_core.sv
